[hw/rtl/lcg_pkg.sv]
// Package for the linear congruential sequence generator.
// Holds the shared constants, the register index codes, the controller states and the
// command and status structs between the controller and the datapath. No dependencies.
package lcg_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_MULTIPLIER = 2'd0,
		CFG_INCREMENT  = 2'd1,
		CFG_MODULUS    = 2'd2,
		CFG_SEED       = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULT,
		ST_FINAL,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath; at most one is set in a cycle.
	typedef struct packed {
		logic load_seed;
		logic load_err;
		logic start;
		logic reduce_step;
		logic mult_step;
		logic final_step;
		logic commit;
	} lcg_cmd_t;

	typedef struct packed {
		logic mod_zero;
	} lcg_status_t;

endpackage

[hw/rtl/lcg_datapath.sv]
// Datapath of the sequence generator: configuration registers, the previous element,
// the shift-subtract reduction units, the modular multiply step and the output register.
// Depends on lcg_pkg.
module lcg_datapath #(
	parameter int VALUE_WIDTH = lcg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lcg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]              cfg_data,
	input  lcg_pkg::lcg_cmd_t                   cmd,
	output lcg_pkg::lcg_status_t                status,
	output logic [VALUE_WIDTH-1:0]              value,
	output logic                                div_error
);

	localparam int W = VALUE_WIDTH;

	logic [W-1:0] mult_q, incr_q, mod_q, seed_q;
	logic [W-1:0] last_q;
	logic [W-1:0] a_sh_q, c_sh_q, b_sh_q;
	logic [W-1:0] ra_q, rc_q, r_q;
	logic [W-1:0] res_q;
	logic         res_err_q;
	logic [W-1:0] value_q;
	logic         div_error_q;

	logic [W:0]   ta, tc, sfin;
	logic [W-1:0] ra_d, rc_d, r_d, fin_d;
	logic [W+1:0] tm;
	lcg_pkg::cfg_reg_t cfg_sel;

	assign cfg_sel = lcg_pkg::cfg_reg_t'(cfg_index);

	// Configuration registers carry their architectural reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= '0;
			incr_q <= '0;
			mod_q  <= W'(1);
			seed_q <= '0;
			last_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_sel)
					lcg_pkg::CFG_MULTIPLIER: mult_q <= cfg_data;
					lcg_pkg::CFG_INCREMENT:  incr_q <= cfg_data;
					lcg_pkg::CFG_MODULUS:    mod_q  <= cfg_data;
					lcg_pkg::CFG_SEED:       seed_q <= cfg_data;
				endcase
			end
			if (cmd.commit && !res_err_q) begin
				last_q <= res_q;
			end
		end
	end

	// Restoring reduction of the multiplier and the increment, one bit each per cycle.
	always_comb begin
		ta = {ra_q, a_sh_q[W-1]};
		tc = {rc_q, c_sh_q[W-1]};
		ra_d = (ta >= {1'b0, mod_q}) ? W'(ta - {1'b0, mod_q}) : ta[W-1:0];
		rc_d = (tc >= {1'b0, mod_q}) ? W'(tc - {1'b0, mod_q}) : tc[W-1:0];
	end

	// Horner step over the previous element, most significant bit first.
	// With r and the reduced multiplier below the modulus, the sum stays below three moduli.
	always_comb begin
		tm = {1'b0, r_q, 1'b0} + {2'b00, (b_sh_q[W-1] ? ra_q : '0)};
		priority if (tm >= {1'b0, mod_q, 1'b0}) begin
			r_d = W'(tm - {1'b0, mod_q, 1'b0});
		end else if (tm >= {2'b00, mod_q}) begin
			r_d = W'(tm - {2'b00, mod_q});
		end else begin
			r_d = tm[W-1:0];
		end
	end

	always_comb begin
		sfin  = {1'b0, r_q} + {1'b0, rc_q};
		fin_d = (sfin >= {1'b0, mod_q}) ? W'(sfin - {1'b0, mod_q}) : sfin[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_sh_q <= mult_q;
			c_sh_q <= incr_q;
			b_sh_q <= last_q;
			ra_q   <= '0;
			rc_q   <= '0;
			r_q    <= '0;
		end
		if (cmd.reduce_step) begin
			a_sh_q <= {a_sh_q[W-2:0], 1'b0};
			c_sh_q <= {c_sh_q[W-2:0], 1'b0};
			ra_q   <= ra_d;
			rc_q   <= rc_d;
		end
		if (cmd.mult_step) begin
			b_sh_q <= {b_sh_q[W-2:0], 1'b0};
			r_q    <= r_d;
		end
		if (cmd.load_seed) begin
			res_q     <= seed_q;
			res_err_q <= 1'b0;
		end
		if (cmd.load_err) begin
			res_q     <= '0;
			res_err_q <= 1'b1;
		end
		if (cmd.final_step) begin
			res_q     <= fin_d;
			res_err_q <= 1'b0;
		end
		if (cmd.commit) begin
			value_q     <= res_q;
			div_error_q <= res_err_q;
		end
	end

	assign status.mod_zero = (mod_q == '0);
	assign value           = value_q;
	assign div_error       = div_error_q;

endmodule

[hw/rtl/lcg_controller.sv]
// Controller of the sequence generator: request decoding, phase sequencing with a bit
// counter, the started flag and the output valid flag. Depends on lcg_pkg.
module lcg_controller #(
	parameter int VALUE_WIDTH = lcg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  lcg_pkg::lcg_status_t status,
	output lcg_pkg::lcg_cmd_t    cmd
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	lcg_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             started_q;
	logic             out_valid_q;
	logic             cnt_last;
	logic             out_free;
	logic             accept;

	assign cnt_last = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == lcg_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcg_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (restart || !started_q || status.mod_zero) begin
						state_d = lcg_pkg::ST_RESULT;
					end else begin
						state_d = lcg_pkg::ST_REDUCE;
					end
				end
			end
			lcg_pkg::ST_REDUCE: begin
				if (cnt_last) state_d = lcg_pkg::ST_MULT;
			end
			lcg_pkg::ST_MULT: begin
				if (cnt_last) state_d = lcg_pkg::ST_FINAL;
			end
			lcg_pkg::ST_FINAL:  state_d = lcg_pkg::ST_RESULT;
			lcg_pkg::ST_RESULT: begin
				if (out_free) state_d = lcg_pkg::ST_IDLE;
			end
			default: state_d = lcg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lcg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					priority if (restart || !started_q) begin
						cmd.load_seed = 1'b1;
					end else if (status.mod_zero) begin
						cmd.load_err = 1'b1;
					end else begin
						cmd.start = 1'b1;
					end
				end
			end
			lcg_pkg::ST_REDUCE: cmd.reduce_step = 1'b1;
			lcg_pkg::ST_MULT:   cmd.mult_step   = 1'b1;
			lcg_pkg::ST_FINAL:  cmd.final_step  = 1'b1;
			lcg_pkg::ST_RESULT: cmd.commit      = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcg_pkg::ST_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == lcg_pkg::ST_REDUCE || state_q == lcg_pkg::ST_MULT) && !cnt_last) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (accept && (restart || !started_q)) begin
				started_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/lcg_sequence_generator.sv]
// Linear congruential sequence generator: x0 = seed, x(n+1) = (a * x(n) + c) mod m.
// A seed word (first request or restart) or a zero-modulus error word goes from the idle state
// through the result state to the output register; a next-element word is set by VALUE_WIDTH
// shift-subtract reduction steps, then VALUE_WIDTH modular multiply steps and a final add step.
// One word is in work at a time: a request is taken only while the block is idle.
// Asynchronous active-low reset: multiplier 0, increment 0, modulus 1, seed 0, not started.
module lcg_sequence_generator #(
	parameter int VALUE_WIDTH = lcg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Config port; the user writes registers only while idle, unchecked by the block.
	input  logic                                cfg_wr_en,
	input  logic [lcg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]              cfg_data,
	// Request channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [VALUE_WIDTH-1:0]              value,
	output logic                                div_error
);

	// The controller decides per request whether the seed, an error word or a new
	// element is produced, and steps the datapath through its phases.
	lcg_pkg::lcg_cmd_t    cmd;
	lcg_pkg::lcg_status_t status;

	lcg_controller #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath first reduces the multiplier and increment by the modulus, then runs a
	// Horner loop over the previous element, so that no full-width product is ever formed.
	// A finished word waits in its output register until the receiver takes it.
	lcg_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.value    (value),
		.div_error(div_error)
	);

endmodule

[hw/rtl/lcg_checker.sv]
// Port-level checker for the sequence generator, bound to the top level.
// Depends on lcg_sequence_generator for the bind target.
module lcg_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [VALUE_WIDTH-1:0] value,
	input logic                   div_error
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(div_error))
		else $error("stalled result word changed");

	// Once a request is taken the block is busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted on consecutive cycles");

	// An error word carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> value == '0)
		else $error("error word with non-zero value");

	// No result word is presented in the cycle after reset is released.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result word valid straight after reset");

endmodule

bind lcg_sequence_generator lcg_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_lcg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.value    (value),
	.div_error(div_error)
);
